// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sjqs_pkg.sv =====
// Package with the shared types, codes and helper functions of the job queue steering block.
package sjqs_pkg;

    localparam int MAX_QUEUES      = 8;
    localparam int QUEUE_BITS      = 3;
    localparam int QUEUE_DEPTH_DEF = 4096;
    localparam int HANDLE_BITS     = 16;
    localparam int PENDING_BITS    = 16;
    localparam int COUNT_CFG_BITS  = 4;
    localparam int CAP_CFG_BITS    = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int IN_DATA_BITS    = 32;
    localparam int OUT_DATA_BITS   = 40;

    localparam logic [COUNT_CFG_BITS-1:0] ACTIVE_RESET   = 4'd4;
    localparam logic [CAP_CFG_BITS-1:0]   CAPACITY_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_KEYED = 2'd0,
        OP_RR    = 2'd1,
        OP_TAKE  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_EMPTY = 3'd2,
        STAT_NULL  = 3'd3,
        STAT_BAD   = 3'd4
    } status_t;

    typedef enum logic {
        CFG_ACTIVE   = 1'b0,
        CFG_CAPACITY = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // Effective queue count: zero acts as one, anything above the maximum as the maximum.
    function automatic logic [COUNT_CFG_BITS-1:0] eff_count(
        input logic [COUNT_CFG_BITS-1:0] active
    );
        logic [COUNT_CFG_BITS-1:0] res;
        if (active == '0)
        begin
            res = 4'd1;
        end
        else if (active > 4'(MAX_QUEUES))
        begin
            res = 4'(MAX_QUEUES);
        end
        else
        begin
            res = active;
        end
        return res;
    endfunction

    // Remainder of an 8-bit value by a count of one to eight, using reciprocal multiplies.
    function automatic logic [QUEUE_BITS-1:0] mod_count(
        input logic [7:0]                val,
        input logic [COUNT_CFG_BITS-1:0] cnt
    );
        logic [16:0] p3;
        logic [16:0] p3h;
        logic [15:0] p5;
        logic [16:0] p7;
        logic [7:0]  r3;
        logic [7:0]  r3h;
        logic [7:0]  r5;
        logic [7:0]  r7;
        logic [QUEUE_BITS-1:0] res;
        p3  = val * 9'd171;
        p3h = {1'b0, val[7:1]} * 9'd171;
        p5  = val * 8'd205;
        p7  = val * 9'd293;
        r3  = val - 8'(p3[16:9] * 8'd3);
        r3h = {1'b0, val[7:1]} - 8'(p3h[16:9] * 8'd3);
        r5  = val - 8'(p5[15:10] * 8'd5);
        r7  = val - 8'(p7[16:11] * 8'd7);
        case (cnt)
            4'd1:    res = 3'd0;
            4'd2:    res = {2'b00, val[0]};
            4'd3:    res = r3[2:0];
            4'd4:    res = {1'b0, val[1:0]};
            4'd5:    res = r5[2:0];
            4'd6:    res = {r3h[1:0], val[0]};
            4'd7:    res = r7[2:0];
            default: res = val[2:0];
        endcase
        return res;
    endfunction

endpackage

// ===== design/sharded_job_queue_steering.sv =====
// Top level of the sharded job queue steering block.
// Each accepted word is one operation on up to eight job FIFOs held in a single job store
// of MAX_QUEUES x QUEUE_DEPTH handles. A word passes an evaluation step, the read-modify-write
// of the chosen queue's pointers and count together with the store write or read, and a load
// step that moves the registered store data into the output register. The block holds one word
// at a time; a held output stalls the load, and the next word is taken in the same cycle that
// the previous result is loaded. The store needs no clearing pass after reset.
module sharded_job_queue_steering #(
    parameter int QUEUE_DEPTH = sjqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [sjqs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: steer_key[7:0], take_queue[10:8], job_handle[26:11], zero fill.
    input  logic [sjqs_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // Fields from bit 0: operation[1:0].
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: status[2:0], queue_chosen[5:3], popped_handle[21:6],
    // pending_total[37:22], zero fill.
    output logic [sjqs_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    sjqs_pkg::ctrl_cmd_t cmd;
    sjqs_pkg::dp_stat_t  stat;

    sjqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sjqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== design/sjqs_datapath.sv =====
// Datapath: configuration, queue pointers and counts, job store and output word register.
module sjqs_datapath #(
    parameter int QUEUE_DEPTH = sjqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sjqs_pkg::ctrl_cmd_t                  cmd,
    output sjqs_pkg::dp_stat_t                   stat,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [sjqs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [1:0]                           s_tuser,
    input  logic [sjqs_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sjqs_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = sjqs_pkg::QUEUE_BITS + PW;
    localparam int QN = sjqs_pkg::MAX_QUEUES;
    localparam int HB = sjqs_pkg::HANDLE_BITS;
    localparam int NB = sjqs_pkg::PENDING_BITS;

    logic [sjqs_pkg::COUNT_CFG_BITS-1:0] active_reg;
    logic [sjqs_pkg::CAP_CFG_BITS-1:0]   cap_reg;

    sjqs_pkg::op_t                   op_reg;
    logic [7:0]                      key_reg;
    logic [sjqs_pkg::QUEUE_BITS-1:0] tq_reg;
    logic [HB-1:0]                   handle_reg;

    logic [PW-1:0]                   head_reg [QN];
    logic [PW-1:0]                   tail_reg [QN];
    logic [CW-1:0]                   cnt_reg  [QN];
    logic [sjqs_pkg::QUEUE_BITS-1:0] rr_reg;
    logic [sjqs_pkg::QUEUE_BITS-1:0] rr_next;
    logic [NB-1:0]                   pend_reg;
    logic [NB-1:0]                   pend_next;

    sjqs_pkg::status_t               res_status_reg;
    sjqs_pkg::status_t               res_status_next;
    logic [sjqs_pkg::QUEUE_BITS-1:0] res_chosen_reg;
    logic [sjqs_pkg::QUEUE_BITS-1:0] res_chosen_next;
    logic                            pop_ok_reg;
    logic [HB-1:0]                   rd_data_reg;

    logic                            m_tvalid_reg;
    logic [sjqs_pkg::OUT_DATA_BITS-1:0] m_data_reg;

    logic [HB-1:0] job_mem [2**AW];

    logic [sjqs_pkg::COUNT_CFG_BITS-1:0] count;
    logic [CW-1:0]                   cap_eff;
    logic                            is_submit;
    logic                            is_take;
    logic [sjqs_pkg::QUEUE_BITS-1:0] key_q;
    logic [sjqs_pkg::QUEUE_BITS-1:0] rr_q;
    logic [sjqs_pkg::QUEUE_BITS-1:0] sub_q;
    logic [sjqs_pkg::QUEUE_BITS-1:0] q_sel;
    logic [CW-1:0]                   cnt_sel;
    logic [PW-1:0]                   head_sel;
    logic [PW-1:0]                   tail_sel;
    logic [PW-1:0]                   head_inc;
    logic [PW-1:0]                   tail_inc;
    logic                            null_job;
    logic                            bad_queue;
    logic                            empty;
    logic                            full;
    logic                            do_push;
    logic                            do_pop;
    logic                            rr_step;
    logic [HB-1:0]                   popped;

    assign count   = sjqs_pkg::eff_count(active_reg);
    assign cap_eff = (32'(cap_reg) > 32'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(cap_reg);

    assign is_submit = (op_reg == sjqs_pkg::OP_KEYED) || (op_reg == sjqs_pkg::OP_RR);
    assign is_take   = (op_reg == sjqs_pkg::OP_TAKE);

    assign key_q = sjqs_pkg::mod_count(key_reg, count);
    assign rr_q  = sjqs_pkg::mod_count({5'b00000, rr_reg}, count);
    assign sub_q = (op_reg == sjqs_pkg::OP_KEYED) ? key_q : rr_q;
    assign q_sel = is_take ? tq_reg : sub_q;

    assign cnt_sel  = cnt_reg[q_sel];
    assign head_sel = head_reg[q_sel];
    assign tail_sel = tail_reg[q_sel];
    assign head_inc = (32'(head_sel) == QUEUE_DEPTH - 1) ? '0 : head_sel + PW'(1);
    assign tail_inc = (32'(tail_sel) == QUEUE_DEPTH - 1) ? '0 : tail_sel + PW'(1);

    assign null_job  = (handle_reg == '0);
    assign bad_queue = ({1'b0, tq_reg} >= count);
    assign empty     = (cnt_sel == '0);
    assign full      = (cnt_sel >= cap_eff);
    assign do_push   = is_submit && !null_job && !full;
    assign do_pop    = is_take && !bad_queue && !empty;
    assign rr_step   = (op_reg == sjqs_pkg::OP_RR) && !null_job;
    assign rr_next   = (({1'b0, rr_q} + 4'd1) == count) ? '0 : rr_q + 3'd1;

    always_comb
    begin
        pend_next = pend_reg;
        if (do_push)
        begin
            pend_next = pend_reg + NB'(1);
        end
        else if (do_pop)
        begin
            pend_next = pend_reg - NB'(1);
        end
    end

    always_comb
    begin
        res_status_next = sjqs_pkg::STAT_OK;
        res_chosen_next = '0;
        if (is_submit)
        begin
            if (null_job)
            begin
                res_status_next = sjqs_pkg::STAT_NULL;
            end
            else
            begin
                res_chosen_next = sub_q;
                if (full)
                begin
                    res_status_next = sjqs_pkg::STAT_FULL;
                end
            end
        end
        else if (is_take)
        begin
            res_chosen_next = tq_reg;
            if (bad_queue)
            begin
                res_status_next = sjqs_pkg::STAT_BAD;
            end
            else if (empty)
            begin
                res_status_next = sjqs_pkg::STAT_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= sjqs_pkg::ACTIVE_RESET;
            cap_reg    <= sjqs_pkg::CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            case (sjqs_pkg::cfg_index_t'(cfg_index))
                sjqs_pkg::CFG_ACTIVE:   active_reg <= cfg_data[sjqs_pkg::COUNT_CFG_BITS-1:0];
                sjqs_pkg::CFG_CAPACITY: cap_reg    <= cfg_data;
                default:                cap_reg    <= cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= sjqs_pkg::op_t'(s_tuser);
            key_reg    <= s_tdata[7:0];
            tq_reg     <= s_tdata[10:8];
            handle_reg <= s_tdata[26:11];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QN; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            rr_reg     <= '0;
            pend_reg   <= '0;
            pop_ok_reg <= 1'b0;
        end
        else if (cmd.eval)
        begin
            if (do_push)
            begin
                tail_reg[q_sel] <= tail_inc;
                cnt_reg[q_sel]  <= cnt_sel + CW'(1);
            end
            if (do_pop)
            begin
                head_reg[q_sel] <= head_inc;
                cnt_reg[q_sel]  <= cnt_sel - CW'(1);
            end
            if (rr_step)
            begin
                rr_reg <= rr_next;
            end
            pend_reg   <= pend_next;
            pop_ok_reg <= do_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            res_status_reg <= res_status_next;
            res_chosen_reg <= res_chosen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && do_push)
        begin
            job_mem[{q_sel, tail_sel}] <= handle_reg;
        end
        if (cmd.eval && is_take)
        begin
            rd_data_reg <= job_mem[{q_sel, head_sel}];
        end
    end

    assign popped = pop_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_data_reg <= {2'b00, pend_reg, popped, res_chosen_reg, res_status_reg};
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_data_reg;

endmodule

// ===== design/sjqs_ctrl.sv =====
// Controller state machine that sequences capture, evaluation and result loading.
module sjqs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sjqs_pkg::dp_stat_t  stat,
    output sjqs_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_EVAL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/sjqs_checker.sv =====
// Port-level assertions for the sharded job queue steering block and their bind statement.
`include "assert_macros.svh"

module sjqs_port_props (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [sjqs_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    logic [2:0]                       out_status;
    logic [sjqs_pkg::QUEUE_BITS-1:0]  out_queue;
    logic [sjqs_pkg::HANDLE_BITS-1:0] out_popped;

    assign out_status = m_tdata[2:0];
    assign out_queue  = m_tdata[5:3];
    assign out_popped = m_tdata[21:6];

    `ASSERT_NEXT(a_one_word_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input accepted while a word is still being evaluated")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled output word changed")
    `ASSERT_SAME(a_status_range, clk, rst_n, m_tvalid, out_status <= sjqs_pkg::STAT_BAD,
        "status code out of range")
    `ASSERT_SAME(a_pop_only_ok, clk, rst_n, m_tvalid && (out_popped != '0),
        out_status == sjqs_pkg::STAT_OK, "popped handle on a failed operation")
    `ASSERT_SAME(a_null_queue_zero, clk, rst_n,
        m_tvalid && (out_status == sjqs_pkg::STAT_NULL),
        out_queue == 3'd0, "null job reported a queue")

endmodule

bind sharded_job_queue_steering sjqs_port_props u_sjqs_port_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/sjqs_checker.sv =====
// Checker that snoops the job queue steering block, predicts every result and compares it.
module sjqs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [sjqs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // Fields from bit 0: steer_key[7:0], take_queue[10:8], job_handle[26:11], zero fill.
    input  logic [sjqs_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // Fields from bit 0: operation[1:0].
    input  logic [1:0]                          s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: status[2:0], queue_chosen[5:3], popped_handle[21:6],
    // pending_total[37:22], zero fill.
    input  logic [sjqs_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output int                                  expected_left,
    output int                                  fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import sjqs_pkg::*;

    typedef struct {
        status_t                 status;
        logic [QUEUE_BITS-1:0]   queue;
        logic [HANDLE_BITS-1:0]  handle;
        logic [PENDING_BITS-1:0] pending;
    } job_result_t;

    logic [HANDLE_BITS-1:0]    shard_fifo [MAX_QUEUES][$];
    job_result_t               result_due_q [$];
    logic [COUNT_CFG_BITS-1:0] active_cfg;
    logic [CAP_CFG_BITS-1:0]   capacity_cfg;
    int unsigned               rr_next;
    int unsigned               jobs_waiting;
    int                        due_count = 0;
    int                        mismatches = 0;

    assign expected_left = due_count;
    assign fail_count    = mismatches;

    function automatic job_result_t apply_job_op(
        input op_t                    op,
        input logic [7:0]             key,
        input logic [QUEUE_BITS-1:0]  tq,
        input logic [HANDLE_BITS-1:0] handle
    );
        job_result_t r;
        int unsigned count;
        int unsigned cap;
        int unsigned q;
        if (active_cfg == '0)
        begin
            count = 1;
        end
        else if (active_cfg > MAX_QUEUES)
        begin
            count = MAX_QUEUES;
        end
        else
        begin
            count = active_cfg;
        end
        cap = (capacity_cfg > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : capacity_cfg;
        r.status = STAT_OK;
        r.queue  = '0;
        r.handle = '0;
        case (op)
            OP_KEYED, OP_RR:
            begin
                if (handle == '0)
                begin
                    r.status = STAT_NULL;
                end
                else
                begin
                    if (op == OP_KEYED)
                    begin
                        q = key % count;
                    end
                    else
                    begin
                        q = rr_next % count;
                        rr_next = (q + 1) % count;
                    end
                    r.queue = q[QUEUE_BITS-1:0];
                    if (shard_fifo[q].size() >= cap)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        shard_fifo[q].push_back(handle);
                        jobs_waiting++;
                    end
                end
            end
            OP_TAKE:
            begin
                r.queue = tq;
                if (tq >= count)
                begin
                    r.status = STAT_BAD;
                end
                else if (shard_fifo[tq].size() == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.handle = shard_fifo[tq].pop_front();
                    jobs_waiting--;
                end
            end
            default:
            begin
            end
        endcase
        r.pending = jobs_waiting[PENDING_BITS-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        job_result_t want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int q = 0; q < MAX_QUEUES; q++)
            begin
                shard_fifo[q].delete();
            end
            result_due_q.delete();
            active_cfg   = ACTIVE_RESET;
            capacity_cfg = CAPACITY_RESET;
            rr_next      = 0;
            jobs_waiting = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_due_q.size() == 0)
                begin
                    $error("result word with no operation outstanding: %h", m_tdata);
                    errs++;
                end
                else
                begin
                    want = result_due_q.pop_front();
                    if (m_tdata[2:0] != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                        errs++;
                    end
                    if (m_tdata[5:3] != want.queue)
                    begin
                        $error("queue_chosen: expected %0d, got %0d", want.queue, m_tdata[5:3]);
                        errs++;
                    end
                    if (m_tdata[21:6] != want.handle)
                    begin
                        $error("popped_handle: expected %h, got %h", want.handle, m_tdata[21:6]);
                        errs++;
                    end
                    if (m_tdata[37:22] != want.pending)
                    begin
                        $error("pending_total: expected %0d, got %0d", want.pending,
                               m_tdata[37:22]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                result_due_q.push_back(apply_job_op(op_t'(s_tuser), s_tdata[7:0],
                                                    s_tdata[10:8], s_tdata[26:11]));
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_ACTIVE)
                begin
                    active_cfg = cfg_data[COUNT_CFG_BITS-1:0];
                end
                else
                begin
                    capacity_cfg = cfg_data[CAP_CFG_BITS-1:0];
                end
            end
        end
        due_count  <= result_due_q.size();
        mismatches <= mismatches + errs;
    end

endmodule

// ===== dv/tb_sharded_job_queue_steering.sv =====
// Testbench top: clock, reset, stimulus and output stalls for the job queue steering block.
module tb_sharded_job_queue_steering;
    timeunit 1ns;
    timeprecision 1ps;

    import sjqs_pkg::*;

    localparam int CYCLE_LIMIT      = 300000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASES           = 12;
    localparam int PHASE_WORDS      = 108;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    cfg_index_t               cfg_index = CFG_ACTIVE;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic [1:0]               s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     long_hold_req = 1'b0;
    int                       expected_left;
    int                       fail_count;
    int unsigned              cycle_count = 0;
    int unsigned              rx_cycle = 0;
    int unsigned              hold_left = 0;
    logic                     hold_seen = 1'b0;
    int                       burst_left = 0;

    sharded_job_queue_steering u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sjqs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .expected_left (expected_left),
        .fail_count    (fail_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL sharded_job_queue_steering");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rx_cycle  <= rx_cycle + 1;
        hold_seen <= long_hold_req;
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (long_hold_req && !hold_seen)
        begin
            hold_left <= LONG_HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 97) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (rx_cycle % 4 == 0);
                default: m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    task automatic send_job(
        input op_t                    op,
        input logic [7:0]             key,
        input logic [QUEUE_BITS-1:0]  tq,
        input logic [HANDLE_BITS-1:0] handle
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, handle, tq, key};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_outstanding();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_left != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        drain_outstanding();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int act;
        int cap;
        int eff;
        int pick;
        int submit_pct;
        op_t op;
        logic [HANDLE_BITS-1:0] handle;
        logic [QUEUE_BITS-1:0] tq;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: four queues, full depth.
        send_job(OP_QUERY, 8'h00, 3'd0, 16'h0000);
        send_job(OP_TAKE,  8'h00, 3'd0, 16'h0000);
        send_job(OP_TAKE,  8'h00, 3'd7, 16'h0000);
        send_job(OP_KEYED, 8'h00, 3'd0, 16'h0000);
        send_job(OP_KEYED, 8'hFF, 3'd7, 16'hFFFF);
        send_job(OP_KEYED, 8'h00, 3'd0, 16'h0001);
        send_job(OP_RR,    8'h00, 3'd0, 16'h5A5A);
        send_job(OP_RR,    8'h00, 3'd0, 16'hA5A5);
        send_job(OP_RR,    8'h00, 3'd0, 16'h0000);
        send_job(OP_RR,    8'h00, 3'd0, 16'h1234);
        send_job(OP_TAKE,  8'h00, 3'd0, 16'h0000);
        send_job(OP_TAKE,  8'h00, 3'd3, 16'h0000);

        // Fewer queues with a stale round-robin pointer, one job per queue.
        write_reg(CFG_ACTIVE, 13'd2);
        write_reg(CFG_CAPACITY, 13'd1);
        send_job(OP_RR,    8'h00, 3'd0, 16'h00FF);
        send_job(OP_TAKE,  8'h00, 3'd2, 16'h0000);
        send_job(OP_KEYED, 8'h81, 3'd0, 16'h8000);

        // Zero count acts as one queue, zero capacity drops everything.
        write_reg(CFG_ACTIVE, 13'd0);
        write_reg(CFG_CAPACITY, 13'd0);
        send_job(OP_KEYED, 8'h7F, 3'd0, 16'h7777);
        send_job(OP_TAKE,  8'h00, 3'd1, 16'h0000);
        send_job(OP_TAKE,  8'h00, 3'd0, 16'h0000);

        // Both registers above their range; jobs beyond the old count come back.
        write_reg(CFG_ACTIVE, 13'd15);
        write_reg(CFG_CAPACITY, 13'd8191);
        send_job(OP_TAKE,  8'h00, 3'd2, 16'h0000);
        send_job(OP_TAKE,  8'h00, 3'd1, 16'h0000);
        send_job(OP_KEYED, 8'hFF, 3'd0, 16'h4321);
        send_job(OP_TAKE,  8'h00, 3'd7, 16'h0000);
        send_job(OP_RR,    8'h00, 3'd0, 16'hFFFF);
        send_job(OP_TAKE,  8'h00, 3'd0, 16'h0000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       act = 1;
                1:       act = 8;
                2:       act = 0;
                3:       act = 15;
                default: act = $urandom_range(0, 15);
            endcase
            case (ph)
                0:       cap = 3;
                1:       cap = 4096;
                2:       cap = 1;
                3:       cap = 8191;
                4:       cap = 0;
                5:       cap = 4097;
                default: cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                            : $urandom_range(1, 6);
            endcase
            write_reg(CFG_ACTIVE, 13'(act));
            write_reg(CFG_CAPACITY, 13'(cap));
            eff = (act == 0) ? 1 : (act > MAX_QUEUES) ? MAX_QUEUES : act;
            submit_pct = $urandom_range(30, 75);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ((ph == 2 || ph == 7) && n == 10)
                begin
                    long_hold_req <= 1'b1;
                end
                else if (n == 12)
                begin
                    long_hold_req <= 1'b0;
                end
                pick = $urandom_range(0, 99);
                if (pick < submit_pct)
                begin
                    op = ($urandom_range(0, 2) == 0) ? OP_RR : OP_KEYED;
                end
                else if (pick < 92)
                begin
                    op = OP_TAKE;
                end
                else
                begin
                    op = OP_QUERY;
                end
                handle = ($urandom_range(0, 19) == 0) ? 16'h0000
                                                      : 16'($urandom_range(1, 65535));
                tq = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, eff - 1));
                send_job(op, 8'($urandom), tq, handle);
            end
        end

        drain_outstanding();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS sharded_job_queue_steering");
        end
        else
        begin
            $display("FAIL sharded_job_queue_steering");
        end
        $finish;
    end

endmodule

// ===== sharded_job_queue_steering.f =====
+incdir+design
design/sjqs_pkg.sv
design/sjqs_datapath.sv
design/sjqs_ctrl.sv
design/sharded_job_queue_steering.sv
design/sjqs_checker.sv
dv/sjqs_checker.sv
dv/tb_sharded_job_queue_steering.sv
